// ----- rtl/mm_pkg.sv -----
// shared constants, types and helpers for the matrix multiplier
`default_nettype none

package mm_pkg;

  localparam int MAX_DIM     = 8;
  localparam int ELEM_WIDTH  = 16;
  localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
  localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  localparam int IDX_W   = 3;              // row / column fields
  localparam int DIM_W   = IDX_W + 1;      // effective sizes 1..MAX_DIM
  localparam int CFG_W   = 4;              // size registers
  localparam int FIELD_W = 16;             // element port width
  localparam int PROD_W  = 35;             // product_value width
  localparam int MUL_W   = 2 * ELEM_WIDTH;
  localparam int ACC_W   = (MUL_W > PROD_W) ? MUL_W : PROD_W;

  localparam int APB_AW  = 4;
  localparam int APB_DW  = 32;

  // input modes
  localparam logic [1:0] MODE_LOAD_A  = 2'd0;
  localparam logic [1:0] MODE_LOAD_B  = 2'd1;
  localparam logic [1:0] MODE_COMPUTE = 2'd2;

  // register indexes
  localparam logic [1:0] REG_ROWS_A     = 2'd0;
  localparam logic [1:0] REG_INNER_SIZE = 2'd1;
  localparam logic [1:0] REG_COLS_B     = 2'd2;

  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_BAD_INDEX = 1'b1;

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_ctl_t;

  // zero acts as one, anything above MAX_DIM acts as MAX_DIM
  function automatic logic [DIM_W-1:0] eff_size(input logic [CFG_W-1:0] v);
    logic [DIM_W-1:0] res;
    if (v == '0) begin
      res = DIM_W'(1);
    end else if (v > CFG_W'(MAX_DIM)) begin
      res = DIM_W'(MAX_DIM);
    end else begin
      res = DIM_W'(v);
    end
    return res;
  endfunction

  function automatic logic [ADDR_W-1:0] store_addr(input logic [IDX_W-1:0] row,
                                                   input logic [IDX_W-1:0] col);
    return ADDR_W'(int'(row) * MAX_DIM + int'(col));
  endfunction

endpackage

`default_nettype wire

// ----- rtl/mm_ram.sv -----
// generic single write port, single read port ram with registered read
`default_nettype none

module mm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/mm_mac.sv -----
// shared multiply-accumulate unit: ram read align, multiply, accumulate
`default_nettype none

module mm_mac (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire mm_pkg::mac_ctl_t              issue,
  input  wire logic [mm_pkg::ELEM_WIDTH-1:0] a_data,
  input  wire logic [mm_pkg::ELEM_WIDTH-1:0] b_data,
  output logic      [mm_pkg::PROD_W-1:0]     acc_out,
  output logic                               done
);

  mm_pkg::mac_ctl_t                      rd_ctl;
  mm_pkg::mac_ctl_t                      mul_ctl;
  logic signed [mm_pkg::MUL_W-1:0]       prod;
  logic signed [mm_pkg::ACC_W-1:0]       prod_ext;
  logic signed [mm_pkg::ACC_W-1:0]       acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ctl  <= '0;
      mul_ctl <= '0;
      done    <= 1'b0;
    end else begin
      // ram data shows up in the cycle after the read is issued
      rd_ctl  <= issue;
      mul_ctl <= rd_ctl;
      done    <= mul_ctl.valid & mul_ctl.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_ctl.valid) begin
      prod <= $signed(a_data) * $signed(b_data);
    end
    if (mul_ctl.valid) begin
      acc <= mul_ctl.first ? prod_ext : acc + prod_ext;
    end
  end

  assign prod_ext = mm_pkg::ACC_W'(prod);
  assign acc_out  = acc[mm_pkg::PROD_W-1:0];

endmodule

`default_nettype wire

// ----- rtl/matrix_multiply.sv -----
// top level: config registers, element stores, sequencer and result register
`default_nettype none

// Dense matrix multiplier. Load items write one Q8.8 element of A or B;
// a load outside the configured sizes returns one result with status 1 and
// stores nothing. A compute item walks the product in row-major order
// through a single multiply-accumulate unit fed by the two element rams,
// one product term per cycle while it reads the terms of an element. Each
// product element passes through the term reads, the ram, multiplier and
// accumulator registers and the result handoff, and waits while the output
// stalls. The block does not take input while a compute item is running.
// Sizes of 0 act as 1 and sizes above 8 act as 8.
module matrix_multiply (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // item input
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [1:0]                      mode,
  input  wire logic [mm_pkg::IDX_W-1:0]        row_index,
  input  wire logic [mm_pkg::IDX_W-1:0]        col_index,
  input  wire logic signed [mm_pkg::FIELD_W-1:0] element,
  // result output
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic      [mm_pkg::IDX_W-1:0]        out_row,
  output logic      [mm_pkg::IDX_W-1:0]        out_col,
  output logic signed [mm_pkg::PROD_W-1:0]     product_value,
  output logic                                 last,
  output logic                                 status,
  // configuration
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [mm_pkg::APB_AW-1:0]       paddr,
  input  wire logic [mm_pkg::APB_DW-1:0]       pwdata,
  output logic      [mm_pkg::APB_DW-1:0]       prdata,
  output logic                                 pready
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MAC  = 2'd1;
  localparam logic [1:0] S_WAIT = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0]                     state;
  logic [mm_pkg::CFG_W-1:0]       rows_a;
  logic [mm_pkg::CFG_W-1:0]       inner_size;
  logic [mm_pkg::CFG_W-1:0]       cols_b;
  logic [mm_pkg::DIM_W-1:0]       nr;
  logic [mm_pkg::DIM_W-1:0]       nk;
  logic [mm_pkg::DIM_W-1:0]       nc;
  logic [mm_pkg::IDX_W-1:0]       r_cnt;
  logic [mm_pkg::IDX_W-1:0]       c_cnt;
  logic [mm_pkg::IDX_W-1:0]       k_cnt;
  logic [1:0]                     reg_sel;

  logic                           in_xfer;
  logic                           out_free;
  logic                           is_load;
  logic [mm_pkg::DIM_W-1:0]       lim_r;
  logic [mm_pkg::DIM_W-1:0]       lim_c;
  logic                           load_bad;
  logic                           k_last;
  logic                           r_last;
  logic                           c_last;

  logic                           we_a;
  logic                           we_b;
  logic [mm_pkg::ADDR_W-1:0]      waddr;
  logic [mm_pkg::ELEM_WIDTH-1:0]  wdata;
  logic                           rd_en;
  logic [mm_pkg::ADDR_W-1:0]      raddr_a;
  logic [mm_pkg::ADDR_W-1:0]      raddr_b;
  logic [mm_pkg::ELEM_WIDTH-1:0]  rdata_a;
  logic [mm_pkg::ELEM_WIDTH-1:0]  rdata_b;
  mm_pkg::mac_ctl_t               issue;
  logic [mm_pkg::PROD_W-1:0]      acc;
  logic                           mac_done;

  // configuration port
  assign pready  = 1'b1;
  assign reg_sel = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_a     <= mm_pkg::CFG_W'(8);
      inner_size <= mm_pkg::CFG_W'(8);
      cols_b     <= mm_pkg::CFG_W'(8);
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_sel)
        mm_pkg::REG_ROWS_A:     rows_a     <= pwdata[mm_pkg::CFG_W-1:0];
        mm_pkg::REG_INNER_SIZE: inner_size <= pwdata[mm_pkg::CFG_W-1:0];
        mm_pkg::REG_COLS_B:     cols_b     <= pwdata[mm_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      mm_pkg::REG_ROWS_A:     prdata = mm_pkg::APB_DW'(rows_a);
      mm_pkg::REG_INNER_SIZE: prdata = mm_pkg::APB_DW'(inner_size);
      mm_pkg::REG_COLS_B:     prdata = mm_pkg::APB_DW'(cols_b);
      default:                prdata = '0;
    endcase
  end

  assign nr = mm_pkg::eff_size(rows_a);
  assign nk = mm_pkg::eff_size(inner_size);
  assign nc = mm_pkg::eff_size(cols_b);

  // input side
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE) && out_free;
  assign in_xfer  = in_valid && in_ready;

  assign is_load  = (mode == mm_pkg::MODE_LOAD_A) || (mode == mm_pkg::MODE_LOAD_B);
  assign lim_r    = (mode == mm_pkg::MODE_LOAD_A) ? nr : nk;
  assign lim_c    = (mode == mm_pkg::MODE_LOAD_A) ? nk : nc;
  assign load_bad = (mm_pkg::DIM_W'(row_index) >= lim_r) ||
                    (mm_pkg::DIM_W'(col_index) >= lim_c);

  assign we_a  = in_xfer && (mode == mm_pkg::MODE_LOAD_A) && !load_bad;
  assign we_b  = in_xfer && (mode == mm_pkg::MODE_LOAD_B) && !load_bad;
  assign waddr = mm_pkg::store_addr(row_index, col_index);
  assign wdata = mm_pkg::ELEM_WIDTH'($unsigned(element));

  // term reads for the current product element
  assign k_last  = (mm_pkg::DIM_W'(k_cnt) + mm_pkg::DIM_W'(1)) == nk;
  assign r_last  = (mm_pkg::DIM_W'(r_cnt) + mm_pkg::DIM_W'(1)) == nr;
  assign c_last  = (mm_pkg::DIM_W'(c_cnt) + mm_pkg::DIM_W'(1)) == nc;
  assign rd_en   = (state == S_MAC);
  assign raddr_a = mm_pkg::store_addr(r_cnt, k_cnt);
  assign raddr_b = mm_pkg::store_addr(k_cnt, c_cnt);

  assign issue.valid = rd_en;
  assign issue.first = (k_cnt == '0);
  assign issue.last  = k_last;

  mm_ram #(
    .WIDTH (mm_pkg::ELEM_WIDTH),
    .DEPTH (mm_pkg::STORE_DEPTH)
  ) u_store_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (waddr),
    .wdata (wdata),
    .re    (rd_en),
    .raddr (raddr_a),
    .rdata (rdata_a)
  );

  mm_ram #(
    .WIDTH (mm_pkg::ELEM_WIDTH),
    .DEPTH (mm_pkg::STORE_DEPTH)
  ) u_store_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (waddr),
    .wdata (wdata),
    .re    (rd_en),
    .raddr (raddr_b),
    .rdata (rdata_b)
  );

  mm_mac u_mac (
    .clk     (clk),
    .rst     (rst),
    .issue   (issue),
    .a_data  (rdata_a),
    .b_data  (rdata_b),
    .acc_out (acc),
    .done    (mac_done)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      r_cnt <= '0;
      c_cnt <= '0;
      k_cnt <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_xfer && (mode == mm_pkg::MODE_COMPUTE)) begin
            r_cnt <= '0;
            c_cnt <= '0;
            k_cnt <= '0;
            state <= S_MAC;
          end
        end
        S_MAC: begin
          if (k_last) begin
            k_cnt <= '0;
            state <= S_WAIT;
          end else begin
            k_cnt <= k_cnt + mm_pkg::IDX_W'(1);
          end
        end
        S_WAIT: begin
          if (mac_done) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            if (r_last && c_last) begin
              state <= S_IDLE;
            end else if (c_last) begin
              c_cnt <= '0;
              r_cnt <= r_cnt + mm_pkg::IDX_W'(1);
              state <= S_MAC;
            end else begin
              c_cnt <= c_cnt + mm_pkg::IDX_W'(1);
              state <= S_MAC;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result register, a new transfer may load while the old one is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((in_xfer && is_load && load_bad) || (state == S_EMIT && out_free)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && is_load && load_bad) begin
      out_row       <= '0;
      out_col       <= '0;
      product_value <= '0;
      last          <= 1'b0;
      status        <= mm_pkg::STATUS_BAD_INDEX;
    end else if (state == S_EMIT && out_free) begin
      out_row       <= r_cnt;
      out_col       <= c_cnt;
      product_value <= $signed(acc);
      last          <= r_last && c_last;
      status        <= mm_pkg::STATUS_OK;
    end
  end

endmodule

`default_nettype wire
